FILE: design/sdpg_pkg.sv
package sdpg_pkg;

  localparam int COUNT_WIDTH       = 32;
  localparam int HALF_PERIOD_WIDTH = 16;
  localparam int ANGLE_WIDTH       = 25;
  localparam int STEP_ANGLE_WIDTH  = 23;
  localparam int SHIFT_WIDTH       = 3;
  localparam int CFG_DATA_WIDTH    = 23;

  // 360 degrees in Q9.16
  localparam logic [ANGLE_WIDTH-1:0] ANGLE_FULL_TURN = 25'd23592960;

  localparam logic [HALF_PERIOD_WIDTH-1:0] HALF_PERIOD_RESET = 16'd1000;
  localparam logic [STEP_ANGLE_WIDTH-1:0]  STEP_ANGLE_RESET  = 23'd117965;
  localparam logic [SHIFT_WIDTH-1:0]       SHIFT_RESET       = 3'd0;

  typedef enum logic [1:0] {
    REG_HALF_PERIOD = 2'd0,
    REG_STEP_ANGLE  = 2'd1,
    REG_USTEP_SHIFT = 2'd2
  } cfg_index_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_t;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] step_count;
    logic               stop_request;
  } in_t;

  typedef struct packed {
    logic                   pulse_level;
    logic                   direction_level;
    logic                   busy_res;
    logic                   move_done;
    logic                   move_aborted;
    logic                   start_rejected;
    logic signed [31:0]     position_steps;
    logic [ANGLE_WIDTH-1:0] angle;
  } out_t;

endpackage

FILE: design/sdpg_angle_step.sv
module sdpg_angle_step (
  input  logic [sdpg_pkg::ANGLE_WIDTH-1:0]      acc,
  input  logic [sdpg_pkg::STEP_ANGLE_WIDTH-1:0] micro,
  input  logic                                  ccw,
  output logic [sdpg_pkg::ANGLE_WIDTH-1:0]      acc_nxt
);
  import sdpg_pkg::*;

  logic [ANGLE_WIDTH:0] acc_w;
  logic [ANGLE_WIDTH:0] micro_w;
  logic [ANGLE_WIDTH:0] full_w;
  logic [ANGLE_WIDTH:0] sum;
  logic [ANGLE_WIDTH:0] res;

  assign acc_w   = {1'b0, acc};
  assign micro_w = (ANGLE_WIDTH + 1)'(micro);
  assign full_w  = {1'b0, ANGLE_FULL_TURN};
  assign sum     = acc_w + micro_w;

  // wrap into one full turn either way
  always_comb begin
    if (ccw) begin
      res = (sum >= full_w) ? (sum - full_w) : sum;
    end else if (acc_w >= micro_w) begin
      res = acc_w - micro_w;
    end else begin
      res = acc_w + full_w - micro_w;
    end
  end

  assign acc_nxt = res[ANGLE_WIDTH-1:0];

endmodule

FILE: design/step_dir_pulse_generator_unit.sv
// Result: each accepted input word gives its result word in the output register in the next cycle.
// Throughput: one word per cycle; the output register lets a new word in
// whenever it is empty or being drained in the same cycle.
// Reset: synchronous, active low; clears position, angle, move state,
// restores the configuration registers to their defaults.
module step_dir_pulse_generator_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sdpg_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sdpg_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [sdpg_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);
  import sdpg_pkg::*;

  localparam logic [31:0] MAG_LIMIT = 32'((64'd1 << (COUNT_WIDTH - 1)) - 64'd1);

  logic [HALF_PERIOD_WIDTH-1:0] half_period_r;
  logic [STEP_ANGLE_WIDTH-1:0]  step_angle_r;
  logic [SHIFT_WIDTH-1:0]       ustep_shift_r;

  logic signed [31:0]           position_r, position_nxt;
  logic [ANGLE_WIDTH-1:0]       angle_r, angle_nxt;
  logic [COUNT_WIDTH-2:0]       steps_left_r, steps_left_nxt;
  logic [HALF_PERIOD_WIDTH-1:0] phase_r, phase_nxt;
  logic                         pulse_high_r, pulse_high_nxt;
  logic                         moving_r, moving_nxt;
  logic                         dir_ccw_r, dir_ccw_nxt;

  logic                         out_valid_r;
  out_t                         out_data_r, out_data_nxt;

  logic                         in_fire;
  logic [HALF_PERIOD_WIDTH-1:0] half_eff;
  logic [HALF_PERIOD_WIDTH-1:0] phase_dec;
  logic [STEP_ANGLE_WIDTH-1:0]  micro;
  logic [ANGLE_WIDTH-1:0]       angle_step;
  logic [31:0]                  raw_mag;
  logic [COUNT_WIDTH-2:0]       mag;
  logic                         level, done, aborted, rejected;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign half_eff  = (half_period_r == '0) ? HALF_PERIOD_WIDTH'(1) : half_period_r;
  assign phase_dec = phase_r - HALF_PERIOD_WIDTH'(1);
  assign micro     = step_angle_r >> ustep_shift_r;
  assign raw_mag   = in_data.step_count[31] ? (32'd0 - in_data.step_count)
                                            : in_data.step_count;
  assign mag       = (raw_mag > MAG_LIMIT) ? MAG_LIMIT[COUNT_WIDTH-2:0]
                                           : raw_mag[COUNT_WIDTH-2:0];

  sdpg_angle_step u_angle (
    .acc     (angle_r),
    .micro   (micro),
    .ccw     (dir_ccw_r),
    .acc_nxt (angle_step)
  );

  always_comb begin
    position_nxt   = position_r;
    angle_nxt      = angle_r;
    steps_left_nxt = steps_left_r;
    phase_nxt      = phase_r;
    pulse_high_nxt = pulse_high_r;
    moving_nxt     = moving_r;
    dir_ccw_nxt    = dir_ccw_r;
    level          = 1'b0;
    done           = 1'b0;
    aborted        = 1'b0;
    rejected       = 1'b0;

    if (in_data.operation == OP_START) begin
      if (moving_r) begin
        rejected = 1'b1;
      end else begin
        dir_ccw_nxt    = !in_data.step_count[31];
        steps_left_nxt = mag;
        pulse_high_nxt = 1'b0;
        phase_nxt      = '0;
        if (mag == '0) begin
          done = 1'b1;
        end else begin
          moving_nxt = 1'b1;
        end
      end
    end else if (moving_r) begin
      if (!pulse_high_r && phase_r == '0) begin
        // sample stop only where a new pulse would begin
        if (in_data.stop_request) begin
          moving_nxt     = 1'b0;
          steps_left_nxt = '0;
          done           = 1'b1;
          aborted        = 1'b1;
        end else begin
          level = 1'b1;
          if (half_eff == HALF_PERIOD_WIDTH'(1)) begin
            pulse_high_nxt = 1'b0;
            phase_nxt      = half_eff;
          end else begin
            pulse_high_nxt = 1'b1;
            phase_nxt      = half_eff - HALF_PERIOD_WIDTH'(1);
          end
        end
      end else if (pulse_high_r) begin
        level     = 1'b1;
        phase_nxt = phase_dec;
        if (phase_dec == '0) begin
          pulse_high_nxt = 1'b0;
          phase_nxt      = half_eff;
        end
      end else begin
        phase_nxt = phase_dec;
        if (phase_dec == '0) begin
          // low phase over: the step is complete
          position_nxt   = dir_ccw_r ? (position_r + 32'sd1) : (position_r - 32'sd1);
          angle_nxt      = angle_step;
          steps_left_nxt = steps_left_r - (COUNT_WIDTH - 1)'(1);
          if (steps_left_r == (COUNT_WIDTH - 1)'(1)) begin
            moving_nxt = 1'b0;
            done       = 1'b1;
          end
        end
      end
    end

    out_data_nxt.pulse_level     = level;
    out_data_nxt.direction_level = dir_ccw_nxt;
    out_data_nxt.busy_res        = moving_nxt;
    out_data_nxt.move_done       = done;
    out_data_nxt.move_aborted    = aborted;
    out_data_nxt.start_rejected  = rejected;
    out_data_nxt.position_steps  = position_nxt;
    out_data_nxt.angle           = angle_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RESET;
      step_angle_r  <= STEP_ANGLE_RESET;
      ustep_shift_r <= SHIFT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HALF_PERIOD: half_period_r <= cfg_data[HALF_PERIOD_WIDTH-1:0];
        REG_STEP_ANGLE:  step_angle_r  <= cfg_data[STEP_ANGLE_WIDTH-1:0];
        REG_USTEP_SHIFT: ustep_shift_r <= cfg_data[SHIFT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r   <= '0;
      angle_r      <= '0;
      steps_left_r <= '0;
      phase_r      <= '0;
      pulse_high_r <= 1'b0;
      moving_r     <= 1'b0;
      dir_ccw_r    <= 1'b1;
    end else if (in_fire) begin
      position_r   <= position_nxt;
      angle_r      <= angle_nxt;
      steps_left_r <= steps_left_nxt;
      phase_r      <= phase_nxt;
      pulse_high_r <= pulse_high_nxt;
      moving_r     <= moving_nxt;
      dir_ccw_r    <= dir_ccw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // hold the result word until it is taken
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

FILE: design/sdpg_checker.sv
module sdpg_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input sdpg_pkg::out_t out_data
);
  import sdpg_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

  a_abort_ends_move: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.move_aborted |-> out_data.move_done && !out_data.busy_res)
    else $error("abort without end of move");

  a_reject_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.start_rejected |->
      out_data.busy_res && !out_data.pulse_level && !out_data.move_done)
    else $error("start rejected while idle");

  a_pulse_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pulse_level |-> out_data.busy_res)
    else $error("pulse driven outside a move");

endmodule

bind step_dir_pulse_generator_unit sdpg_checker u_sdpg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import sdpg_pkg::*;

  typedef struct {
    bit   fixed;
    out_t word;
  } typed_status_t;

  typedef struct {
    in_t  word;
    bit   fixed;
    out_t status;
  } script_row_t;

  localparam int FAST_ROW    = 5;
  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 105;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  in_t                       in_data   = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  out_t                      out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [1:0]                cfg_index = REG_HALF_PERIOD;
  logic [CFG_DATA_WIDTH-1:0] cfg_data  = '0;

  // mirror of the configuration registers
  logic [HALF_PERIOD_WIDTH-1:0] p_half  = HALF_PERIOD_RESET;
  logic [STEP_ANGLE_WIDTH-1:0]  p_angle = STEP_ANGLE_RESET;
  logic [SHIFT_WIDTH-1:0]       p_shift = SHIFT_RESET;

  // mirror of the motion state
  logic signed [31:0]     m_pos    = '0;
  logic [ANGLE_WIDTH-1:0] m_angle  = '0;
  logic [30:0]            m_left   = '0;
  logic [15:0]            m_phase  = '0;
  logic                   m_high   = 1'b0;
  logic                   m_moving = 1'b0;
  logic                   m_ccw    = 1'b1;

  out_t          status_q[$];
  typed_status_t typed_q[$];
  int            words_sent      = 0;
  int            words_checked   = 0;
  int            mismatch_count  = 0;
  bit            sender_gaps     = 1'b0;
  bit            receiver_stalls = 1'b0;
  int            half_now        = 1000;

  script_row_t script [19] = '{
    '{'{OP_TICK,  -32'sd1, 1'b1}, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 32'sd0, 25'd0}},
    '{'{OP_START, 32'sd0,  1'b0}, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 32'sd0, 25'd0}},
    '{'{OP_START, -32'sd1, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 32'sd0, 25'd0}},
    '{'{OP_START, 32'sd7,  1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 32'sd0, 25'd0}},
    '{'{OP_TICK,  32'sd0,  1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 32'sd0, 25'd0}},
    '{'{OP_START, 32'h7FFF_FFFF, 1'b0}, 1'b0, '0},
    '{'{OP_TICK,  32'h5A5A_A5A5, 1'b0}, 1'b0, '0},
    '{'{OP_TICK,  32'hA5A5_5A5A, 1'b0}, 1'b0, '0},
    '{'{OP_TICK,  32'hFFFF_FFFF, 1'b1}, 1'b0, '0},
    '{'{OP_START, 32'h8000_0000, 1'b1}, 1'b0, '0},
    '{'{OP_TICK,  32'h0000_0000, 1'b0}, 1'b0, '0},
    '{'{OP_TICK,  32'h1234_5678, 1'b0}, 1'b0, '0},
    '{'{OP_TICK,  32'h8765_4321, 1'b0}, 1'b0, '0},
    '{'{OP_TICK,  32'h0F0F_F0F0, 1'b0}, 1'b0, '0},
    '{'{OP_TICK,  32'hF0F0_0F0F, 1'b1}, 1'b0, '0},
    '{'{OP_START, 32'sd1,  1'b0}, 1'b0, '0},
    '{'{OP_TICK,  32'h3C3C_C3C3, 1'b0}, 1'b0, '0},
    '{'{OP_TICK,  32'hC3C3_3C3C, 1'b1}, 1'b0, '0},
    '{'{OP_TICK,  32'h6969_9696, 1'b1}, 1'b0, '0}
  };

  step_dir_pulse_generator_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic out_t advance_motion(in_t w);
    out_t                        r;
    logic [31:0]                 mag;
    logic [HALF_PERIOD_WIDTH-1:0] h;
    logic [STEP_ANGLE_WIDTH-1:0]  micro;
    r = '0;
    h = (p_half == '0) ? 16'd1 : p_half;
    if (w.operation == OP_START) begin
      if (m_moving) begin
        r.start_rejected = 1'b1;
      end else begin
        mag = w.step_count[31] ? (32'd0 - w.step_count) : w.step_count;
        if (mag > 32'h7FFF_FFFF) mag = 32'h7FFF_FFFF;
        m_ccw   = !w.step_count[31];
        m_left  = mag[30:0];
        m_high  = 1'b0;
        m_phase = '0;
        if (mag == 32'd0) r.move_done = 1'b1;
        else m_moving = 1'b1;
      end
    end else if (m_moving) begin
      if (!m_high && m_phase == '0) begin
        // stop is only honoured where a new pulse would begin
        if (w.stop_request) begin
          m_moving       = 1'b0;
          m_left         = '0;
          r.move_done    = 1'b1;
          r.move_aborted = 1'b1;
        end else begin
          r.pulse_level = 1'b1;
          if (h == 16'd1) begin
            m_high  = 1'b0;
            m_phase = h;
          end else begin
            m_high  = 1'b1;
            m_phase = h - 16'd1;
          end
        end
      end else if (m_high) begin
        r.pulse_level = 1'b1;
        m_phase = m_phase - 16'd1;
        if (m_phase == '0) begin
          m_high  = 1'b0;
          m_phase = h;
        end
      end else begin
        m_phase = m_phase - 16'd1;
        if (m_phase == '0) begin
          micro = p_angle >> p_shift;
          if (m_ccw) begin
            m_pos   = m_pos + 32'sd1;
            m_angle = m_angle + micro;
            if (m_angle >= ANGLE_FULL_TURN) m_angle = m_angle - ANGLE_FULL_TURN;
          end else begin
            m_pos = m_pos - 32'sd1;
            if (m_angle >= micro) m_angle = m_angle - micro;
            else m_angle = m_angle + ANGLE_FULL_TURN - micro;
          end
          m_left = m_left - 31'd1;
          if (m_left == '0) begin
            m_moving    = 1'b0;
            r.move_done = 1'b1;
          end
        end
      end
    end
    r.direction_level = m_ccw;
    r.busy_res        = m_moving;
    r.position_steps  = m_pos;
    r.angle           = m_angle;
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_t          want;
    typed_status_t t;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          $error("result word arrived with nothing expected");
          mismatch_count++;
        end else begin
          want = status_q.pop_front();
          check_field("pulse_level", want.pulse_level, out_data.pulse_level);
          check_field("direction_level", want.direction_level, out_data.direction_level);
          check_field("busy_res", want.busy_res, out_data.busy_res);
          check_field("move_done", want.move_done, out_data.move_done);
          check_field("move_aborted", want.move_aborted, out_data.move_aborted);
          check_field("start_rejected", want.start_rejected, out_data.start_rejected);
          check_field("position_steps", want.position_steps, out_data.position_steps);
          check_field("angle", want.angle, out_data.angle);
          words_checked++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HALF_PERIOD: p_half  = cfg_data[HALF_PERIOD_WIDTH-1:0];
          REG_STEP_ANGLE:  p_angle = cfg_data[STEP_ANGLE_WIDTH-1:0];
          REG_USTEP_SHIFT: p_shift = cfg_data[SHIFT_WIDTH-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        t = typed_q.pop_front();
        want = advance_motion(in_data);
        status_q.push_back(t.fixed ? t.word : want);
      end
    end
  end

  // result side: random back-pressure bursts
  initial begin
    forever begin
      @(posedge clk);
      if (receiver_stalls && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_word(in_t w, bit fixed, out_t status);
    typed_status_t t;
    if (sender_gaps && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    t.fixed = fixed;
    t.word  = status;
    typed_q.push_back(t);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (words_checked != words_sent) @(posedge clk);
  endtask

  task automatic configure(int half, int step_angle, int shift);
    cfg_valid <= 1'b1;
    cfg_index <= REG_HALF_PERIOD;
    cfg_data  <= CFG_DATA_WIDTH'(half);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_STEP_ANGLE;
    cfg_data  <= CFG_DATA_WIDTH'(step_angle);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_USTEP_SHIFT;
    cfg_data  <= CFG_DATA_WIDTH'(shift);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    half_now = (half == 0) ? 1 : half;
  endtask

  function automatic in_t tick_word(bit stop);
    in_t w;
    w.operation    = OP_TICK;
    w.step_count   = $urandom;
    w.stop_request = stop;
    return w;
  endfunction

  function automatic in_t start_word(int count);
    in_t w;
    w.operation    = OP_START;
    w.step_count   = count;
    w.stop_request = $urandom_range(0, 1);
    return w;
  endfunction

  // one start followed by enough ticks to finish it, or a stop burst for long moves and some short ones
  task automatic run_move();
    int pick;
    int count;
    int ticks;
    bit aborting;
    pick = $urandom_range(0, 9);
    case (pick)
      0: count = 0;
      1: count = $urandom;
      2: count = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: begin
        count = $urandom_range(1, 4);
        if ($urandom_range(0, 1)) count = -count;
      end
    endcase
    aborting = !(count >= -4 && count <= 4) || $urandom_range(0, 7) == 0;
    send_word(start_word(count), 1'b0, '0);
    if (aborting) ticks = $urandom_range(0, 4 * half_now);
    else ticks = 2 * half_now * (count < 0 ? -count : count) + $urandom_range(0, 2);
    repeat (ticks) begin
      if ($urandom_range(0, 23) == 0)
        send_word(start_word($urandom_range(0, 6) - 3), 1'b0, '0);
      else
        send_word(tick_word($urandom_range(0, 31) == 0), 1'b0, '0);
    end
    // a run of stop ticks longer than one period is sure to hit a pulse start
    if (aborting) repeat (2 * half_now + 1) send_word(tick_word(1'b1), 1'b0, '0);
  endtask

  initial begin
    int first;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (i == FAST_ROW) begin
        wait_quiet();
        configure(0, 5898240, 0);
      end
      send_word(script[i].word, script[i].fixed, script[i].status);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_quiet();
      case (p)
        0: configure(1, 8388607, 0);
        1: configure(2, 1, 7);
        2: configure(0, 5898240, 5);
        default: configure($urandom_range(0, 4), $urandom_range(1, 5898240),
                           $urandom_range(0, 7));
      endcase
      sender_gaps     = ($urandom_range(0, 3) != 0);
      receiver_stalls = ($urandom_range(0, 3) != 0);
      first = words_sent;
      while (words_sent - first < PHASE_WORDS) run_move();
      // drop any move still running before the next register change
      repeat (2 * half_now + 1) send_word(tick_word(1'b1), 1'b0, '0);
    end

    // longest half period with steady flow on both sides
    wait_quiet();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    configure(65535, $urandom_range(1, 8388607), $urandom_range(0, 7));
    send_word(start_word(5), 1'b0, '0);
    send_word(tick_word(1'b0), 1'b0, '0);
    repeat (200) begin
      if ($urandom_range(0, 19) == 0) send_word(start_word($urandom), 1'b0, '0);
      else send_word(tick_word($urandom_range(0, 1)), 1'b0, '0);
    end

    wait_quiet();
    repeat (8) @(posedge clk);
    if (status_q.size() != 0) begin
      $error("%0d result words never arrived", status_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule

FILE: step_dir_pulse_generator_unit.f
design/sdpg_pkg.sv
design/sdpg_angle_step.sv
design/step_dir_pulse_generator_unit.sv
design/sdpg_checker.sv
tb/testbench.sv
